FILE: rtl/core/hs_pkg.sv
package hs_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_ROWS_DEF  = 1024;

   localparam logic [10:0] WIDTH_RESET   = 11'd1024;
   localparam logic [10:0] ROWS_RESET    = 11'd1024;
   localparam logic [15:0] SPACING_RESET = 16'd256;
   localparam logic [7:0]  AMBIENT_RESET = 8'd64;

   // twice the sun elevation term, sqrt(2) in Q16.16
   localparam logic [34:0] TWO_ALT_Q16 = 35'd92682;
   localparam logic [16:0] D16_ONE     = 17'd65536;

   typedef enum logic [1:0] {
      CSR_WIDTH,
      CSR_ROWS,
      CSR_SPACING,
      CSR_AMBIENT
   } hs_csr_type;

   typedef struct packed {
      logic       frame_end;
      logic [9:0] row_index;
      logic [9:0] column;
   } hs_info_type;

   typedef struct packed {
      hs_info_type info;
      logic [15:0] mag_x;
      logic        neg_x;
      logic [1:0]  span_x;
      logic [15:0] mag_z;
      logic        neg_z;
      logic [1:0]  span_z;
   } hs_grad_type;

   typedef struct packed {
      hs_info_type info;
      logic [7:0]  shade;
   } hs_result_type;

endpackage

FILE: rtl/core/hs_div.sv
module hs_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 18,
   parameter int Q_W   = 32,
   parameter int TAG_W = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_q,
   output logic             out_ovf,
   output logic [TAG_W-1:0] out_tag
);

   localparam int HI_W  = NUM_W - Q_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [Q_W:0]     v_ff;
   logic [DEN_W-1:0] rem_ff [Q_W+1];
   logic [Q_W-1:0]   low_ff [Q_W+1];
   logic [Q_W-1:0]   q_ff   [Q_W+1];
   logic [DEN_W-1:0] den_ff [Q_W+1];
   logic [Q_W:0]     ovf_ff;
   logic [TAG_W-1:0] tag_ff [Q_W+1];

   logic [HI_W-1:0]  hi;
   logic             ovf_in;

   always_comb begin
      hi     = in_num[NUM_W-1:Q_W];
      ovf_in = CMP_W'(hi) >= CMP_W'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= ovf_in ? '0 : DEN_W'(hi);
         low_ff[0] <= in_num[Q_W-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= in_den;
         ovf_ff[0] <= ovf_in;
         tag_ff[0] <= in_tag;
      end
   end

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [DEN_W:0] rs;
      logic [DEN_W:0] diff;
      logic           ge;

      always_comb begin
         rs   = {rem_ff[k], low_ff[k][Q_W-1]};
         diff = rs - {1'b0, den_ff[k]};
         ge   = rs >= {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) begin
            rem_ff[k+1] <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
            low_ff[k+1] <= {low_ff[k][Q_W-2:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][Q_W-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign out_valid = v_ff[Q_W];
   assign out_q     = q_ff[Q_W];
   assign out_ovf   = ovf_ff[Q_W];
   assign out_tag   = tag_ff[Q_W];

endmodule

FILE: rtl/core/hs_sqrt.sv
module hs_sqrt #(
   parameter int ROOT_W = 32,
   parameter int TAG_W  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] in_val,
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [TAG_W-1:0]    out_tag
);

   localparam int VW    = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic [ROOT_W:0]    v_ff;
   logic [REM_W-1:0]   rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]  root_ff [ROOT_W+1];
   logic [VW-1:0]      val_ff  [ROOT_W+1];
   logic [TAG_W-1:0]   tag_ff  [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         val_ff[0]  <= in_val;
         tag_ff[0]  <= in_tag;
      end
   end

   // one root bit per stage: bring down two radicand bits and try root*4+1
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0] rs;
      logic [REM_W-1:0] trial;
      logic             ge;

      always_comb begin
         rs    = {rem_ff[k][REM_W-3:0], val_ff[k][VW-1:VW-2]};
         trial = {1'b0, root_ff[k], 2'b01};
         ge    = rs >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) begin
            rem_ff[k+1]  <= ge ? rs - trial : rs;
            root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], ge};
            val_ff[k+1]  <= {val_ff[k][VW-3:0], 2'b00};
            tag_ff[k+1]  <= tag_ff[k];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_tag   = tag_ff[ROOT_W];

endmodule

FILE: rtl/core/hs_win.sv
module hs_win #(
   parameter int MAX_WIDTH = hs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_ROWS  = hs_pkg::MAX_ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic                             pos_clear,
   input  logic [15:0]                      in_sample,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   w_eff,
   input  logic [$clog2(MAX_ROWS+1)-1:0]    r_eff,
   output logic                             out_valid,
   output hs_pkg::hs_grad_type              out_grad
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_ROWS + 1);

   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          col_last, drain;
   logic [AW-1:0] addr_b;

   logic [15:0]   mem0_ff [MAX_WIDTH];
   logic [15:0]   mem1_ff [MAX_WIDTH];
   logic [15:0]   rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;

   logic          v1_ff;
   logic [15:0]   cur1_ff;
   logic          hl1_ff, hr1_ff, hu1_ff, drain1_ff, par1_ff;
   hs_pkg::hs_info_type info1_ff;
   logic [15:0]   prev_mid_ff;

   logic [15:0]   mid, right, up, left, down;
   logic [16:0]   dx, dz;

   always_comb begin
      col_last = (32'(col_ff) + 1) == 32'(w_eff);
      drain    = 32'(row_ff) == 32'(r_eff);
      addr_b   = (32'(col_ff) + 1 == MAX_WIDTH) ? '0 : AW'(32'(col_ff) + 1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (col_last) begin
         col_in = '0;
         row_in = drain ? '0 : RW'(32'(row_ff) + 1);
      end else begin
         col_in = AW'(32'(col_ff) + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || pos_clear) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (in_valid) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // rows alternate between the two stores; the one the current row fills
   // still holds the row two above, read before it is overwritten
   always_ff @(posedge clock) begin
      if (in_valid) begin
         rd0a_ff <= mem0_ff[col_ff];
         rd0b_ff <= mem0_ff[addr_b];
         rd1a_ff <= mem1_ff[col_ff];
         rd1b_ff <= mem1_ff[addr_b];
         if (!drain && !row_ff[0]) begin
            mem0_ff[col_ff] <= in_sample;
         end
         if (!drain && row_ff[0]) begin
            mem1_ff[col_ff] <= in_sample;
         end
         cur1_ff             <= in_sample;
         hl1_ff              <= col_ff != '0;
         hr1_ff              <= !col_last;
         hu1_ff              <= 32'(row_ff) > 1;
         drain1_ff           <= drain;
         par1_ff             <= row_ff[0];
         info1_ff.column     <= 10'(col_ff);
         info1_ff.row_index  <= 10'(32'(row_ff) - 1);
         info1_ff.frame_end  <= col_last && drain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid && (row_ff != '0);
      end
   end

   always_comb begin
      mid   = par1_ff ? rd0a_ff : rd1a_ff;
      right = hr1_ff ? (par1_ff ? rd0b_ff : rd1b_ff) : mid;
      up    = hu1_ff ? (par1_ff ? rd1a_ff : rd0a_ff) : mid;
      left  = hl1_ff ? prev_mid_ff : mid;
      down  = drain1_ff ? mid : cur1_ff;
      dx    = {right[15], right} - {left[15], left};
      dz    = {down[15], down} - {up[15], up};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= v1_ff;
      end
      if (en && v1_ff) begin
         prev_mid_ff <= mid;
      end
      if (en) begin
         out_grad.info   <= info1_ff;
         out_grad.neg_x  <= dx[16];
         out_grad.mag_x  <= dx[16] ? 16'(-dx) : dx[15:0];
         out_grad.span_x <= {1'b0, hl1_ff} + {1'b0, hr1_ff};
         out_grad.neg_z  <= dz[16];
         out_grad.mag_z  <= dz[16] ? 16'(-dz) : dz[15:0];
         out_grad.span_z <= {1'b0, hu1_ff} + {1'b0, !drain1_ff};
      end
   end

endmodule

FILE: rtl/core/heightmap_hillshade.sv
// A pixel's shade is computed only once the sample below it has been accepted.
// Throughput: one request per cycle while the output skid is empty, set by the
// fully pipelined slope dividers, square root and shade divider (one quotient
// or root bit a stage).
// Reset: synchronous; clears valid bits, frame position and registers to
// their defaults. Line stores are not cleared.
module heightmap_hillshade #(
   parameter int MAX_WIDTH = hs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_ROWS  = hs_pkg::MAX_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] height_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] shade, [17:8] column, [27:18] row_index
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int INFO_W = $bits(hs_pkg::hs_info_type);

   logic [10:0] width_ff, rows_ff;
   logic [15:0] spacing_ff;
   logic [7:0]  ambient_ff;
   logic [CW-1:0] w_eff;
   logic [RW-1:0] r_eff;
   logic [15:0]   spacing_eff;

   logic en, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= hs_pkg::WIDTH_RESET;
         rows_ff    <= hs_pkg::ROWS_RESET;
         spacing_ff <= hs_pkg::SPACING_RESET;
         ambient_ff <= hs_pkg::AMBIENT_RESET;
      end else if (csr_we) begin
         unique case (hs_pkg::hs_csr_type'(csr_index))
            hs_pkg::CSR_WIDTH:   width_ff   <= csr_data[10:0];
            hs_pkg::CSR_ROWS:    rows_ff    <= csr_data[10:0];
            hs_pkg::CSR_SPACING: spacing_ff <= csr_data;
            hs_pkg::CSR_AMBIENT: ambient_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (rows_ff == '0) begin
         r_eff = RW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         r_eff = RW'(MAX_ROWS);
      end else begin
         r_eff = RW'(rows_ff);
      end
      spacing_eff = (spacing_ff == '0) ? 16'd1 : spacing_ff;
   end

   // ---- line stores and stencil ----
   logic                w_valid;
   hs_pkg::hs_grad_type w_grad;

   assign accept = req_tvalid && en;

   hs_win #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_win (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .pos_clear (csr_we),
      .in_sample (req_tdata),
      .w_eff     (w_eff),
      .r_eff     (r_eff),
      .out_valid (w_valid),
      .out_grad  (w_grad)
   );

   // ---- slopes ----
   logic [17:0] den_x, den_z;
   logic        dx_v, dz_v, dx_ovf, dz_ovf;
   logic [31:0] qx, qz;
   logic [1:0]  tag_x;
   logic [INFO_W+1:0] tag_z;

   always_comb begin
      den_x = (w_grad.span_x == 2'd2) ? {1'b0, spacing_eff, 1'b0} : {2'b00, spacing_eff};
      den_z = (w_grad.span_z == 2'd2) ? {1'b0, spacing_eff, 1'b0} : {2'b00, spacing_eff};
   end

   hs_div #(.NUM_W(33), .DEN_W(18), .Q_W(32), .TAG_W(2)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (w_valid),
      .in_num    ({1'b0, w_grad.mag_x, 16'b0}),
      .in_den    (den_x),
      .in_tag    ({w_grad.neg_x, w_grad.span_x == 2'd0}),
      .out_valid (dx_v),
      .out_q     (qx),
      .out_ovf   (dx_ovf),
      .out_tag   (tag_x)
   );

   hs_div #(.NUM_W(33), .DEN_W(18), .Q_W(32), .TAG_W(INFO_W + 2)) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (w_valid),
      .in_num    ({1'b0, w_grad.mag_z, 16'b0}),
      .in_den    (den_z),
      .in_tag    ({w_grad.neg_z, w_grad.span_z == 2'd0, w_grad.info}),
      .out_valid (dz_v),
      .out_q     (qz),
      .out_ovf   (dz_ovf),
      .out_tag   (tag_z)
   );

   // saturate at a slope of 32768 and form the dot numerator
   logic [31:0] mag_x, mag_z;
   logic signed [33:0] sx, sz;
   logic signed [34:0] n2_in;

   always_comb begin
      mag_x = tag_x[0] ? '0 :
              ((dx_ovf || (qx[31] && qx[30:0] != '0)) ? 32'h8000_0000 : qx);
      mag_z = tag_z[INFO_W] ? '0 :
              ((dz_ovf || (qz[31] && qz[30:0] != '0)) ? 32'h8000_0000 : qz);
      sx    = tag_x[1] ? -$signed({2'b00, mag_x}) : $signed({2'b00, mag_x});
      sz    = tag_z[INFO_W+1] ? -$signed({2'b00, mag_z}) : $signed({2'b00, mag_z});
      n2_in = $signed({sx[33], sx}) - $signed({sz[33], sz}) + $signed(hs_pkg::TWO_ALT_Q16);
   end

   logic        b_v_ff, c_v_ff, d_v_ff;
   logic [31:0] ax_b_ff, az_b_ff;
   logic [34:0] n2_b_ff, n2_c_ff, n2_d_ff;
   hs_pkg::hs_info_type info_b_ff, info_c_ff, info_d_ff;
   logic [63:0] sqx_c_ff, sqz_c_ff, s_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= dx_v && dz_v;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
      if (en) begin
         ax_b_ff   <= mag_x;
         az_b_ff   <= mag_z;
         n2_b_ff   <= n2_in;
         info_b_ff <= tag_z[INFO_W-1:0];
         sqx_c_ff  <= 64'(ax_b_ff) * 64'(ax_b_ff);
         sqz_c_ff  <= 64'(az_b_ff) * 64'(az_b_ff);
         n2_c_ff   <= n2_b_ff;
         info_c_ff <= info_b_ff;
         s_d_ff    <= (64'd1 << 32) + sqx_c_ff + sqz_c_ff;
         n2_d_ff   <= n2_c_ff;
         info_d_ff <= info_c_ff;
      end
   end

   // ---- normal length ----
   logic        r_v;
   logic [31:0] root;
   logic [34+INFO_W:0] r_tag;

   hs_sqrt #(.ROOT_W(32), .TAG_W(35 + INFO_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_v_ff),
      .in_val    (s_d_ff),
      .in_tag    ({n2_d_ff, info_d_ff}),
      .out_valid (r_v),
      .out_root  (root),
      .out_tag   (r_tag)
   );

   logic [34:0] n2_r;
   logic        n2_pos;
   logic [47:0] d_num;

   always_comb begin
      n2_r   = r_tag[34+INFO_W:INFO_W];
      n2_pos = !n2_r[34] && (n2_r != '0);
      d_num  = n2_pos ? {n2_r[32:0], 15'b0} : '0;
   end

   logic        q_v, q_ovf;
   logic [16:0] q16;
   logic [INFO_W:0] q_tag;

   hs_div #(.NUM_W(48), .DEN_W(32), .Q_W(17), .TAG_W(INFO_W + 1)) u_div_d (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_v),
      .in_num    (d_num),
      .in_den    (root),
      .in_tag    ({n2_pos, r_tag[INFO_W-1:0]}),
      .out_valid (q_v),
      .out_q     (q16),
      .out_ovf   (q_ovf),
      .out_tag   (q_tag)
   );

   // ---- shade ----
   logic [16:0] d16;
   logic        f_v_ff, g_v_ff;
   logic [25:0] t_f_ff;
   hs_pkg::hs_info_type info_f_ff;
   hs_pkg::hs_result_type g_d_ff;
   logic [24:0] s24;
   logic [32:0] acc;

   always_comb begin
      if (!q_tag[INFO_W]) begin
         d16 = '0;
      end else if (q_ovf || q16 > hs_pkg::D16_ONE) begin
         d16 = hs_pkg::D16_ONE;
      end else begin
         d16 = q16;
      end
      s24 = {1'b0, ambient_ff, 16'b0} + 25'(t_f_ff);
      acc = {s24, 8'b0} - 33'(s24) + (33'd1 << 23);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= q_v;
         g_v_ff <= f_v_ff;
      end
      if (en) begin
         t_f_ff       <= (9'd256 - {1'b0, ambient_ff}) * d16;
         info_f_ff    <= q_tag[INFO_W-1:0];
         g_d_ff.shade <= acc[31:24];
         g_d_ff.info  <= info_f_ff;
      end
   end

   // ---- output register with skid ----
   logic                  out_v_ff, skid_v_ff;
   hs_pkg::hs_result_type out_d_ff, skid_d_ff;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= g_v_ff;
         end
      end else if (g_v_ff && en) begin
         // result still waiting: park the new one
         skid_v_ff <= 1'b1;
      end
      if (!out_v_ff || rsp_tready) begin
         out_d_ff <= skid_v_ff ? skid_d_ff : g_d_ff;
      end
      if (out_v_ff && !rsp_tready && en) begin
         skid_d_ff <= g_d_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0, out_d_ff.info.row_index, out_d_ff.info.column, out_d_ff.shade};
   assign rsp_tlast  = out_d_ff.info.frame_end;

   a_skid_implies_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a result while the output register is empty");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready && g_v_ff && !skid_v_ff) |=> skid_v_ff)
      else $error("stalled result not parked in skid");

   a_stall_freeze : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(g_d_ff))
      else $error("pipeline moved while stalled");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = hs_pkg::CSR_WIDTH;
   logic [15:0] csr_data = '0;

   typedef struct packed {
      logic [7:0] shade;
      logic [9:0] column;
      logic [9:0] row_index;
      logic       frame_end;
   } shade_px_type;

   class shade_board;
      int unsigned   img_w, img_h, spacing, ambient;
      int unsigned   in_col, in_row;
      logic signed [31:0] mid_line[1024];
      logic signed [31:0] up_line[1024];
      logic signed [31:0] prev_mid;
      shade_px_type  pending[$];
      int unsigned   errors;

      function new();
         img_w = 1024; img_h = 1024; spacing = 256; ambient = 64;
         in_col = 0; in_row = 0; prev_mid = 0; errors = 0;
         foreach (mid_line[i]) begin
            mid_line[i] = 0;
            up_line[i] = 0;
         end
      endfunction

      function void write_reg(hs_pkg::hs_csr_type idx, logic [15:0] val);
         unique case (idx)
            hs_pkg::CSR_WIDTH:   img_w = val[10:0];
            hs_pkg::CSR_ROWS:    img_h = val[10:0];
            hs_pkg::CSR_SPACING: spacing = val;
            hs_pkg::CSR_AMBIENT: ambient = val[7:0];
         endcase
         in_col = 0;
         in_row = 0;
      endfunction

      function longint slope(longint dh, int unsigned span, int unsigned sp);
         longint unsigned mag;
         if (span == 0) return 0;
         mag = (dh < 0) ? -dh : dh;
         mag = (mag << 16) / (longint'(span) * sp);
         if (mag > 64'h8000_0000) mag = 64'h8000_0000;
         return (dh < 0) ? -longint'(mag) : longint'(mag);
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function logic [7:0] lambert(longint sx, longint sz);
         longint n2;
         longint unsigned d16, ax, az, s24;
         n2 = sx - sz + 92682;
         d16 = 0;
         if (n2 > 0) begin
            ax = (sx < 0) ? -sx : sx;
            az = (sz < 0) ? -sz : sz;
            d16 = (longint'(n2) << 15) / int_sqrt((64'd1 << 32) + ax * ax + az * az);
            if (d16 > 65536) d16 = 65536;
         end
         s24 = (longint'(ambient) << 16) + longint'(256 - ambient) * d16;
         return 8'((255 * s24 + (64'd1 << 23)) >> 24);
      endfunction

      function void note_height(logic [15:0] h);
         int unsigned w, r, sp, col, z;
         logic signed [31:0] cur, mid, lft, rgt, upv, dnv;
         bit drain, hl, hr, hu;
         shade_px_type px;
         w = (img_w < 1) ? 1 : (img_w > 1024 ? 1024 : img_w);
         r = (img_h < 1) ? 1 : (img_h > 1024 ? 1024 : img_h);
         sp = (spacing == 0) ? 1 : spacing;
         if (in_col >= w) in_col = 0;
         if (in_row > r) in_row = 0;
         col = in_col;
         cur = 32'($signed(h));
         if (in_row == 0) begin
            mid_line[col] = cur;
         end else begin
            z = in_row - 1;
            drain = (in_row == r);
            hl = col > 0;
            hr = col + 1 < w;
            hu = z > 0;
            mid = mid_line[col];
            lft = hl ? prev_mid : mid;
            rgt = hr ? mid_line[col + 1] : mid;
            upv = hu ? up_line[col] : mid;
            dnv = drain ? mid : cur;
            px.shade = lambert(slope(rgt - lft, int'(hl) + int'(hr), sp),
                               slope(dnv - upv, int'(hu) + int'(!drain), sp));
            px.column = col[9:0];
            px.row_index = z[9:0];
            px.frame_end = (col + 1 == w) && (z + 1 == r);
            pending.push_back(px);
            up_line[col] = mid;
            prev_mid = mid;
            if (!drain) mid_line[col] = cur;
         end
         in_col = col + 1;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row > r) in_row = 0;
         end
      endfunction

      function void check_pixel(logic [31:0] data, logic last);
         shade_px_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %h last %b",
                     $time, data, last);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (data[7:0] !== want.shade) begin
            $display("%0t: shade expected %0d actual %0d", $time, want.shade, data[7:0]);
            errors++;
         end
         if (data[17:8] !== want.column) begin
            $display("%0t: column expected %0d actual %0d", $time, want.column, data[17:8]);
            errors++;
         end
         if (data[27:18] !== want.row_index) begin
            $display("%0t: row expected %0d actual %0d",
                     $time, want.row_index, data[27:18]);
            errors++;
         end
         if (last !== want.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time, want.frame_end, last);
            errors++;
         end
      endfunction
   endclass

   shade_board board;
   bit         idle_on = 1'b1;
   int         hold_off = 0;

   heightmap_hillshade u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // response side: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_pixel(rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         gap = idle_on ? $urandom_range(0, 17) : 0;
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_height(logic [15:0] h);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (idle_on && $urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= h;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_height(h);
   endtask

   task automatic settle();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (board.pending.size() != 0 && guard < 2_000_000) begin
         @(posedge clock);
         guard++;
      end
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(hs_pkg::hs_csr_type idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      board.write_reg(idx, val);
   endtask

   // one frame plus its drain row; random noise, alternating extremes or a noisy ramp
   task automatic run_frame(int unsigned w, int unsigned r, int mode);
      int unsigned k;
      logic [15:0] h;
      for (k = 0; k < w * (r + 1); k++) begin
         case (mode)
            0: h = 16'($urandom());
            1: h = (k % 2) ? 16'h7FFF : 16'h8000;
            2: h = 16'(k * 37 + $urandom_range(0, 63));
            default: h = 16'h0000;
         endcase
         send_height(h);
      end
   endtask

   task automatic setup(logic [15:0] w, logic [15:0] r, logic [15:0] sp,
                        logic [15:0] amb);
      settle();
      write_reg(hs_pkg::CSR_WIDTH, w);
      write_reg(hs_pkg::CSR_ROWS, r);
      write_reg(hs_pkg::CSR_SPACING, sp);
      write_reg(hs_pkg::CSR_AMBIENT, amb);
   endtask

   initial begin
      int unsigned w, r;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of height, spacing, ambient, single-row and -column
      setup(4, 3, 1, 0);
      run_frame(4, 3, 1);
      setup(1, 1, 16'hFFFF, 255);
      run_frame(1, 1, 1);
      setup(3, 1, 0, 128);
      run_frame(3, 1, 0);
      setup(1, 4, 256, 64);
      run_frame(1, 4, 1);

      // block fills up while the receiver holds off
      setup(32, 7, 32, 64);
      idle_on = 1'b0;
      hold_off = 300;
      run_frame(32, 7, 0);
      idle_on = 1'b1;

      // zero width and rows count as one; keep frames small
      setup(0, 0, 256, 64);
      run_frame(1, 1, 2);

      while (board.errors == 0 && w < 1000) begin
         w = $urandom_range(1, 8);
         r = $urandom_range(1, 5);
         setup(16'(w), 16'(r),
               16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 600)),
               16'($urandom_range(0, 255)));
         run_frame(w, r, $urandom_range(0, 3) == 0 ? 0 : 2);
         w = 0;
         r = 0;
         if ($urandom_range(0, 1)) run_frame(0, 0, 0);
         w = 1000;
      end
      for (int f = 0; f < 12; f++) begin
         w = $urandom_range(1, 8);
         r = $urandom_range(1, 4);
         setup(16'(w), 16'(r),
               16'($urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(1, 600)),
               16'($urandom_range(0, 255)));
         run_frame(w, r, $urandom_range(0, 3) == 0 ? 0 : 2);
      end
      settle();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/hs_pkg.sv
rtl/core/hs_div.sv
rtl/core/hs_sqrt.sv
rtl/core/hs_win.sv
rtl/core/heightmap_hillshade.sv
tb/sv/tb_top.sv
